// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL; included by the top-level file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked on every rising clock edge outside reset.
`define MIE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication with the consequent checked in the next cycle.
`define MIE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MIE_ASSERT(label, clk, rst_n, prop, msg)
`define MIE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hdl/mie_pkg.sv -----
// Package for the modular inverse block: constants, microcode types and program ROM.
package mie_pkg;

    localparam int MOD_WIDTH_DEF = 30;
    localparam logic [63:0] MOD_RESET = 64'd1073741789;
    localparam int OPERAND_W = 32;
    localparam int STEP_W = 4;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_LOAD       = 3'd1,
        OP_DIV_REDUCE = 3'd2,
        OP_SET_NR     = 3'd3,
        OP_DIV_STEP   = 3'd4,
        OP_UPDATE     = 3'd5,
        OP_FIX        = 3'd6,
        OP_OUT        = 3'd7
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_START = 3'd2,
        C_MOD_ZERO = 3'd3,
        C_DIV_BUSY = 3'd4,
        C_NR_ZERO  = 3'd5
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    // step addresses
    localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] S_CHK_MOD  = 4'd1;
    localparam logic [STEP_W-1:0] S_REDUCE   = 4'd2;
    localparam logic [STEP_W-1:0] S_RED_WAIT = 4'd3;
    localparam logic [STEP_W-1:0] S_SET_NR   = 4'd4;
    localparam logic [STEP_W-1:0] S_LOOP     = 4'd5;
    localparam logic [STEP_W-1:0] S_DIV      = 4'd6;
    localparam logic [STEP_W-1:0] S_DIV_WAIT = 4'd7;
    localparam logic [STEP_W-1:0] S_UPDATE   = 4'd8;
    localparam logic [STEP_W-1:0] S_FIX      = 4'd9;
    localparam logic [STEP_W-1:0] S_OUT      = 4'd10;

    // microcode ROM
    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl w;
        case (step)
            S_IDLE:     w = '{OP_LOAD,       C_NO_START, S_IDLE};
            S_CHK_MOD:  w = '{OP_NONE,       C_MOD_ZERO, S_OUT};
            S_REDUCE:   w = '{OP_DIV_REDUCE, C_NEXT,     S_IDLE};
            S_RED_WAIT: w = '{OP_NONE,       C_DIV_BUSY, S_RED_WAIT};
            S_SET_NR:   w = '{OP_SET_NR,     C_NEXT,     S_IDLE};
            S_LOOP:     w = '{OP_NONE,       C_NR_ZERO,  S_FIX};
            S_DIV:      w = '{OP_DIV_STEP,   C_NEXT,     S_IDLE};
            S_DIV_WAIT: w = '{OP_NONE,       C_DIV_BUSY, S_DIV_WAIT};
            S_UPDATE:   w = '{OP_UPDATE,     C_ALWAYS,   S_LOOP};
            S_FIX:      w = '{OP_FIX,        C_NEXT,     S_IDLE};
            S_OUT:      w = '{OP_OUT,        C_ALWAYS,   S_IDLE};
            default:    w = '{OP_NONE,       C_ALWAYS,   S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/mie_divmac.sv -----
// Restoring divider, one quotient bit per cycle, with quotient-times-coefficient accumulation.
module mie_divmac #(
    parameter int MOD_WIDTH  = mie_pkg::MOD_WIDTH_DEF,
    parameter int DIVIDEND_W = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [DIVIDEND_W-1:0]       i_dividend,
    input  logic [MOD_WIDTH-1:0]        i_divisor,
    input  logic signed [MOD_WIDTH+1:0] i_mul,
    output logic                        o_busy,
    output logic [MOD_WIDTH-1:0]        o_rem,
    output logic signed [MOD_WIDTH+1:0] o_acc
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]            r_cnt;
    logic [MOD_WIDTH-1:0]        r_rem;
    logic [DIVIDEND_W-1:0]       r_quo;
    logic [MOD_WIDTH-1:0]        r_div;
    logic signed [MOD_WIDTH+1:0] r_mul;
    logic signed [MOD_WIDTH+1:0] r_acc;

    logic [MOD_WIDTH:0] rem_sh;
    logic [MOD_WIDTH:0] diff;
    logic               qbit;

    // partial remainder stays below twice the divisor, so the top bit is the borrow
    assign rem_sh = {r_rem, r_quo[DIVIDEND_W-1]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign qbit   = ~diff[MOD_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_go) begin
            r_cnt <= CNT_W'(DIVIDEND_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
            r_mul <= i_mul;
            r_acc <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= qbit ? diff[MOD_WIDTH-1:0] : rem_sh[MOD_WIDTH-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b0};
            // Horner: acc = 2*acc + qbit*mul, quotient bits arrive MSB first
            r_acc <= (r_acc <<< 1) + (qbit ? r_mul : '0);
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_rem;
    assign o_acc  = r_acc;

endmodule

// ----- hdl/modular_inverse_euclid.sv -----
// Top level: modular inverse by the extended Euclidean algorithm, microcoded control.
//
// Use:
//   Configuration: i_cfg_we with i_cfg_wdata writes the modulus (reset value
//   2^30 - 35, truncated to MOD_WIDTH). Write only while busy is low.
//   Input: an operand transfer happens on a rising edge with start high and
//   busy low. busy stays high until the result has been shown.
//   Output: o_done is high for exactly one cycle with o_inverse valid; the
//   receiver must take it then, it cannot hold the block off.
// Flow: the divider works on an N-bit dividend, N = max(32, MOD_WIDTH); k is
//   the number of Euclid division steps. The operand is first reduced mod the
//   modulus by one divider run, then each division step runs it once more; with
//   modulus 0 no division is done and o_done follows the modulus check. busy drops
//   in the cycle after o_done, so the next transfer can follow at once. For a
//   30-bit prime k is mostly 15-25; the one-bit-per-cycle divider sets the run time.
// Reset: synchronous, active low; returns the sequencer to its wait step and
//   the modulus to its default. Any item in flight is dropped.
module modular_inverse_euclid #(
    parameter int MOD_WIDTH = mie_pkg::MOD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [31:0]          i_operand,
    input  logic                 i_cfg_we,
    input  logic [MOD_WIDTH-1:0] i_cfg_wdata,
    output logic                 o_done,
    output logic [MOD_WIDTH-1:0] o_inverse
);

    `include "assert_macros.svh"

    localparam int OPW   = mie_pkg::OPERAND_W;
    localparam int DIV_N = (MOD_WIDTH > OPW) ? MOD_WIDTH : OPW;
    localparam int TW    = MOD_WIDTH + 2;   // signed coefficient width, |t| <= modulus

    // sequencer
    logic [mie_pkg::STEP_W-1:0] r_step;
    logic [mie_pkg::STEP_W-1:0] n_step;
    mie_pkg::t_ctrl             ctrl;
    logic                       take;

    // datapath registers
    logic [MOD_WIDTH-1:0]  r_modulus;
    logic [OPW-1:0]        r_a;
    logic [MOD_WIDTH-1:0]  r_r;
    logic [MOD_WIDTH-1:0]  r_nr;
    logic signed [TW-1:0]  r_t;
    logic signed [TW-1:0]  r_nt;

    // divider hookup
    logic                 div_go;
    logic [DIV_N-1:0]     div_dividend;
    logic [MOD_WIDTH-1:0] div_divisor;
    logic signed [TW-1:0] div_mul;
    logic                 div_busy;
    logic [MOD_WIDTH-1:0] div_rem;
    logic signed [TW-1:0] div_acc;

    assign ctrl = mie_pkg::ucode(r_step);

    // jump decision
    always_comb begin
        case (ctrl.cond)
            mie_pkg::C_NEXT:     take = 1'b0;
            mie_pkg::C_ALWAYS:   take = 1'b1;
            mie_pkg::C_NO_START: take = ~start;
            mie_pkg::C_MOD_ZERO: take = (r_modulus == '0);
            mie_pkg::C_DIV_BUSY: take = div_busy;
            mie_pkg::C_NR_ZERO:  take = (r_nr == '0);
            default:             take = 1'b1;
        endcase
    end

    assign n_step = take ? ctrl.target : r_step + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= mie_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= mie_pkg::MOD_RESET[MOD_WIDTH-1:0];
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_wdata;
        end
    end

    // divider operand select: reduction of the operand, or r / nr in the loop
    always_comb begin
        div_go       = 1'b0;
        div_dividend = DIV_N'(r_r);
        div_divisor  = r_nr;
        div_mul      = r_nt;
        case (ctrl.op)
            mie_pkg::OP_DIV_REDUCE: begin
                div_go       = 1'b1;
                div_dividend = DIV_N'(r_a);
                div_divisor  = r_modulus;
                div_mul      = '0;
            end
            mie_pkg::OP_DIV_STEP: begin
                div_go = 1'b1;
            end
            default: begin
                div_go = 1'b0;
            end
        endcase
    end

    mie_divmac #(
        .MOD_WIDTH  (MOD_WIDTH),
        .DIVIDEND_W (DIV_N)
    ) u_divmac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (div_go),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_mul      (div_mul),
        .o_busy     (div_busy),
        .o_rem      (div_rem),
        .o_acc      (div_acc)
    );

    // Euclid datapath
    always_ff @(posedge i_clk) begin
        case (ctrl.op)
            mie_pkg::OP_LOAD: begin
                // reloaded every idle cycle; the value at the transfer edge sticks
                r_a  <= i_operand;
                r_r  <= r_modulus;
                r_t  <= '0;
                r_nt <= TW'(1);
            end
            mie_pkg::OP_SET_NR: begin
                r_nr <= div_rem;
            end
            mie_pkg::OP_UPDATE: begin
                // (r, nr) <- (nr, r mod nr); (t, nt) <- (nt, t - q*nt)
                r_r  <= r_nr;
                r_nr <= div_rem;
                r_t  <= r_nt;
                r_nt <= r_t - div_acc;
            end
            mie_pkg::OP_FIX: begin
                if (r_t[TW-1]) begin
                    r_t <= r_t + $signed({2'b00, r_modulus});
                end
            end
            default: begin
            end
        endcase
    end

    assign busy      = (r_step != mie_pkg::S_IDLE);
    assign o_done    = (ctrl.op == mie_pkg::OP_OUT);
    assign o_inverse = r_t[MOD_WIDTH-1:0];

    `MIE_ASSERT(a_done_only_busy, i_clk, i_rst_n, !o_done || busy, "result strobe while idle")
    `MIE_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "no busy after transfer")
    `MIE_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !busy && !o_done, "not idle after result")

endmodule

// ----- tb/modular_inverse_euclid_tb.sv -----
// Self-checking testbench for the modular inverse block, scoreboard class included.
`timescale 1ns / 100ps

module modular_inverse_euclid_tb;

    localparam int MW = mie_pkg::MOD_WIDTH_DEF;

    // Slowest correct run: about 1000 items, each with k near 45 division steps for a
    // Fibonacci-like 30-bit pair and behind the longest sender gap; the limit sits above it.
    localparam int unsigned CYCLE_LIMIT = 16_000_000;

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the modulus, works out the inverse
    // of every accepted operand and compares each shown result with the
    // oldest inverse still waiting.
    // ------------------------------------------------------------------
    class inverse_tracker;
        logic [MW-1:0] modulus;
        logic [MW-1:0] pending_inverses[$];
        int            failures;

        function new();
            modulus  = mie_pkg::MOD_RESET[MW-1:0];
            failures = 0;
        endfunction

        // Extended Euclid on (m, a mod m). Coefficients live in 64-bit two's
        // complement; their magnitude never exceeds m, so wraparound is exact.
        function logic [MW-1:0] euclid_inverse(logic [31:0] a, logic [MW-1:0] m);
            bit [63:0] t, nt, r, nr, q, tmp;
            if (m == '0) begin
                return '0;
            end
            t  = 64'd0;
            nt = 64'd1;
            r  = 64'(m);
            nr = 64'(a) % 64'(m);
            while (nr != 64'd0) begin
                q   = r / nr;
                tmp = nt;
                nt  = t - q * nt;
                t   = tmp;
                tmp = nr;
                nr  = r - q * nr;
                r   = tmp;
            end
            // negative coefficient: bring it into range
            if (t[63]) begin
                t = t + 64'(m);
            end
            return t[MW-1:0];
        endfunction

        function void note_operand(logic [31:0] operand);
            pending_inverses.push_back(euclid_inverse(operand, modulus));
        endfunction

        function void check_inverse(logic [MW-1:0] got);
            logic [MW-1:0] want;
            if (pending_inverses.size() == 0) begin
                $error("inverse: result %0d shown with no transfer outstanding", got);
                failures++;
            end else begin
                want = pending_inverses.pop_front();
                if (got !== want) begin
                    $error("inverse: expected %0d, actual %0d", want, got);
                    failures++;
                end
            end
        endfunction

        function int pending();
            return pending_inverses.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals and instance
    // ------------------------------------------------------------------
    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic [31:0]   i_operand;
    logic          i_cfg_we;
    logic [MW-1:0] i_cfg_wdata;
    logic          o_done;
    logic [MW-1:0] o_inverse;

    inverse_tracker tracker = new();
    int unsigned    cycle_count = 0;

    modular_inverse_euclid u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_operand  (i_operand),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_done     (o_done),
        .o_inverse  (o_inverse)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Result side: the strobe lasts one cycle and cannot be held off, so
    // every rising edge with o_done high is a result transfer.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            tracker.check_inverse(o_inverse);
        end
    end

    // Watchdog: a hung sequencer or a lost strobe ends up here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, tracker.pending());
            $display("[modular_inverse_euclid] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Sender idle time: mostly none or a few cycles, now and then a long
    // stretch so that start rises at any point of the block's iteration.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)      return 0;
        else if (roll < 85) return $urandom_range(1, 4);
        else if (roll < 96) return $urandom_range(5, 60);
        else                return $urandom_range(100, 1500);
    endfunction

    // Operand mix: plenty of full-width values, plus small values, exact
    // multiples of the modulus (congruent to zero), values just below a
    // multiple, the top of the 32-bit range and values at or just above m.
    function automatic logic [31:0] pick_operand(logic [MW-1:0] m);
        bit [63:0]   span;
        logic [31:0] v;
        int          sel;
        v   = $urandom;
        sel = $urandom_range(0, 9);
        case (sel)
            5: begin
                v = $urandom_range(0, 255);
            end
            6, 7: begin
                if (m != '0) begin
                    span = 64'hFFFF_FFFF / 64'(m);
                    v    = 32'(64'(m) * (64'($urandom) % (span + 64'd1)));
                    if (sel == 7 && v != 32'd0) begin
                        v = v - 32'd1;
                    end
                end
            end
            8: begin
                v = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
            end
            9: begin
                v = 32'(64'(m) + 64'($urandom_range(0, 2)));
            end
            default: ;
        endcase
        return v;
    endfunction

    // One operand transfer. start is only lowered when a gap is wanted, so
    // back-to-back items keep it high across the boundary.
    task automatic send_operand(input logic [31:0] operand, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start     <= 1'b1;
        i_operand <= operand;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.note_operand(operand);
    endtask

    // Stop sending and wait for every outstanding inverse and for busy to drop.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // Modulus write, only once the block is idle.
    task automatic write_modulus(input logic [MW-1:0] m);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        tracker.modulus = m;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= MW'($urandom);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [31:0]   reset_ops[12];
        logic [31:0]   zero_mod_ops[3];
        logic [31:0]   unit_mod_ops[3];
        logic [31:0]   composite_ops[3];
        logic [MW-1:0] phase_mod[13];
        int            phase_items[13];
        bit            quiet;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_operand   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset modulus 2^30-35. Zero, one, two, m-1, m, m+1, 2m, the
        // edges of the 32-bit operand range and alternating bit patterns.
        reset_ops = '{32'd0, 32'd1, 32'd2, 32'd1073741788, 32'd1073741789,
                      32'd1073741790, 32'd2147483578, 32'hFFFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
        foreach (reset_ops[i]) send_operand(reset_ops[i], pick_gap());

        // modulus of zero: no division, inverse 0
        zero_mod_ops = '{32'd0, 32'd5, 32'hFFFF_FFFF};
        write_modulus('0);
        foreach (zero_mod_ops[i]) send_operand(zero_mod_ops[i], 0);

        // modulus of one: everything reduces to zero
        unit_mod_ops = '{32'd0, 32'd7, 32'hFFFF_FFFF};
        write_modulus(MW'(1));
        foreach (unit_mod_ops[i]) send_operand(unit_mod_ops[i], pick_gap());

        // composite modulus: gcd above one hands back the raw coefficient
        composite_ops = '{32'd4, 32'd5, 32'd9};
        write_modulus(MW'(6));
        foreach (composite_ops[i]) send_operand(composite_ops[i], 0);

        // Random phases. Small moduli keep the Euclid loop short, so most
        // items go there; the full-width moduli get fewer but still many.
        phase_mod   = '{MW'(2), MW'(3), MW'(97), MW'(1009), MW'(65537), MW'(0),
                        MW'(1000), MW'(0), MW'(1), MW'(30'h3FFF_FFFF),
                        MW'(1073741789), MW'(0), MW'(7)};
        phase_items = '{60, 60, 80, 80, 70, 80, 50, 30, 30, 60, 200, 100, 60};
        phase_mod[5]  = MW'($urandom_range(3, 65535) | 1);
        phase_mod[11] = MW'($urandom);

        foreach (phase_mod[p]) begin
            write_modulus(phase_mod[p]);
            // some phases run flat out with no sender gaps between items
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < phase_items[p]; n++) begin
                // sender holds back until the block has emptied
                if ($urandom_range(0, 59) == 0) begin
                    drain();
                end
                send_operand(pick_operand(phase_mod[p]), quiet ? 0 : pick_gap());
            end
        end

        drain();
        // busy drops the cycle after the strobe; a short margin catches strays
        repeat (20) @(posedge i_clk);

        if (tracker.failures == 0 && tracker.pending() == 0) begin
            $display("[modular_inverse_euclid] OK");
        end else begin
            $display("[modular_inverse_euclid] ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mie_pkg.sv
hdl/mie_divmac.sv
hdl/modular_inverse_euclid.sv
tb/modular_inverse_euclid_tb.sv
